[hdl/skc_pkg.sv]
// Shared types and constants of the soft-knee compressor curve unit.
// No dependencies; every other file in this folder refers to it by scoped names.
package skc_pkg;

  typedef struct packed {
    logic valid;
    logic neg;
    logic bypass;
  } skc_ctrl_t;

  typedef enum logic [2:0] {
    REG_KNEE_LOW  = 3'd0,
    REG_KNEE_HIGH = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_KNEE_INV  = 3'd3,
    REG_INV_RATIO = 3'd4
  } skc_reg_t;

  localparam int unsigned LEVEL_W    = 24;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned LOG_STEPS  = 16;
  localparam int unsigned EXP_STEPS  = 16;
  localparam int unsigned SQRT_ITERS = 31;
  localparam int unsigned SQ_STAGES  = EXP_STEPS * SQRT_ITERS;
  localparam int unsigned FRAC_Q     = 16;
  localparam int unsigned EXPO_W     = 7;
  localparam int unsigned LOG_W      = EXPO_W + FRAC_Q;
  localparam int unsigned PROD_W     = 41;
  localparam int unsigned N_W        = 22;
  localparam int unsigned IP_W       = 6;
  localparam int unsigned ROOT_W     = 31;
  localparam int unsigned VAL_W      = 62;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 24'h80_0000;
  localparam logic [RATIO_W-1:0] RATIO_ONE   = 17'h1_0000;
  localparam logic [ROOT_W-1:0]  ROOT_ONE    = 31'h4000_0000;

endpackage

[hdl/skc_if.sv]
// Channel interfaces of the soft-knee compressor curve unit: sample in, sample out, config.
// Depends on skc_pkg for the configuration field widths.
interface skc_in_if #(parameter int W = 24) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface skc_out_if #(parameter int W = 24) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface skc_cfg_if ();
  logic                               valid;
  logic                               ready;
  logic [skc_pkg::CFG_IDX_W-1:0]      index;
  logic [skc_pkg::LEVEL_W-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/skc_front.sv]
// Front end: sign split, region select against the knee levels, then normalization
// of sample and anchor level for the log unit. Two register stages. Uses skc_pkg.
module skc_front #(
  parameter int W = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [W-1:0]                       sample,
  input  logic [skc_pkg::LEVEL_W-1:0]        k_low,
  input  logic [skc_pkg::LEVEL_W-1:0]        k_high,
  input  logic [skc_pkg::LEVEL_W-1:0]        thr,
  input  logic [skc_pkg::RATIO_W-1:0]        knee_a,
  input  logic [skc_pkg::RATIO_W-1:0]        full_a,
  output skc_pkg::skc_ctrl_t                 ctrl_o,
  output logic [W-1:0]                       x_o,
  output logic [W-1:0]                       mx_o,
  output logic [W-1:0]                       mk_o,
  output logic [$clog2(W)-1:0]               px_o,
  output logic [$clog2(W)-1:0]               pk_o,
  output logic [skc_pkg::RATIO_W-1:0]        a_o
);
  localparam int PW = $clog2(W);
  localparam int CW = (W + 1 > skc_pkg::LEVEL_W + 1) ? W + 1 : skc_pkg::LEVEL_W + 1;
  localparam logic [CW-1:0] FS_C = {{(CW-1){1'b0}}, 1'b1} << (W - 1);

  function automatic logic [W-1:0] clamp_lvl(input logic [skc_pkg::LEVEL_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return (e > FS_C) ? FS_C[W-1:0] : e[W-1:0];
  endfunction

  function automatic logic [skc_pkg::RATIO_W-1:0] clamp_ratio(
    input logic [skc_pkg::RATIO_W-1:0] v);
    return (v > skc_pkg::RATIO_ONE) ? skc_pkg::RATIO_ONE : v;
  endfunction

  function automatic logic [PW+W-1:0] normalize(input logic [W-1:0] v);
    logic [W-1:0]  vv;
    logic [PW-1:0] p;
    vv = (v == '0) ? W'(1) : v;
    p  = '0;
    for (int k = 0; k < W; k++) begin
      if (vv[k]) p = PW'(k);
    end
    return {p, vv << (PW'(W - 1) - p)};
  endfunction

  skc_pkg::skc_ctrl_t          a_ctrl_r, a_ctrl_nxt;
  logic [W-1:0]                a_x_r, a_x_nxt;
  logic [W-1:0]                a_k_r, a_k_nxt;
  logic [skc_pkg::RATIO_W-1:0] a_a_r, a_a_nxt;
  logic [W-1:0]                k1, k2, th;
  logic                        in_knee;
  logic [PW+W-1:0]             nx, nk;

  always_comb begin
    k1                = clamp_lvl(k_low);
    k2                = clamp_lvl(k_high);
    th                = clamp_lvl(thr);
    a_ctrl_nxt.valid  = in_valid;
    a_ctrl_nxt.neg    = sample[W-1];
    a_x_nxt           = sample[W-1] ? (~sample + W'(1)) : sample;
    a_ctrl_nxt.bypass = (a_x_nxt <= k1);
    in_knee           = (a_x_nxt <= k2);
    a_k_nxt           = (a_ctrl_nxt.bypass || in_knee) ? k1 : th;
    a_a_nxt           = in_knee ? clamp_ratio(knee_a) : clamp_ratio(full_a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctrl_r.valid <= 1'b0;
    end else if (en) begin
      a_ctrl_r <= a_ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r <= a_x_nxt;
      a_k_r <= a_k_nxt;
      a_a_r <= a_a_nxt;
    end
  end

  always_comb begin
    nx = normalize(a_x_r);
    nk = normalize(a_k_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o <= a_ctrl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o  <= a_x_r;
      a_o  <= a_a_r;
      px_o <= nx[PW+W-1:W];
      mx_o <= nx[W-1:0];
      pk_o <= nk[PW+W-1:W];
      mk_o <= nk[W-1:0];
    end
  end

endmodule

[hdl/skc_log_step.sv]
// One fraction bit of log2 for sample and anchor level: square the mantissa,
// renormalize and shift the result bit in. One register stage. Uses skc_pkg.
module skc_log_step #(
  parameter int W = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  skc_pkg::skc_ctrl_t          ctrl_i,
  input  logic [W-1:0]                x_i,
  input  logic [W-1:0]                mx_i,
  input  logic [W-1:0]                mk_i,
  input  logic [skc_pkg::FRAC_Q-1:0]  frx_i,
  input  logic [skc_pkg::FRAC_Q-1:0]  frk_i,
  input  logic [$clog2(W)-1:0]        px_i,
  input  logic [$clog2(W)-1:0]        pk_i,
  input  logic [skc_pkg::RATIO_W-1:0] a_i,
  output skc_pkg::skc_ctrl_t          ctrl_o,
  output logic [W-1:0]                x_o,
  output logic [W-1:0]                mx_o,
  output logic [W-1:0]                mk_o,
  output logic [skc_pkg::FRAC_Q-1:0]  frx_o,
  output logic [skc_pkg::FRAC_Q-1:0]  frk_o,
  output logic [$clog2(W)-1:0]        px_o,
  output logic [$clog2(W)-1:0]        pk_o,
  output logic [skc_pkg::RATIO_W-1:0] a_o
);
  logic [2*W-1:0] sqx, sqk;
  logic [W:0]     tx, tk;
  logic [W-1:0]   mx_nxt, mk_nxt;

  always_comb begin
    sqx    = {{W{1'b0}}, mx_i} * {{W{1'b0}}, mx_i};
    sqk    = {{W{1'b0}}, mk_i} * {{W{1'b0}}, mk_i};
    tx     = sqx[2*W-1:W-1];
    tk     = sqk[2*W-1:W-1];
    mx_nxt = tx[W] ? tx[W:1] : tx[W-1:0];
    mk_nxt = tk[W] ? tk[W:1] : tk[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o   <= x_i;
      mx_o  <= mx_nxt;
      mk_o  <= mk_nxt;
      frx_o <= {frx_i[skc_pkg::FRAC_Q-2:0], tx[W]};
      frk_o <= {frk_i[skc_pkg::FRAC_Q-2:0], tk[W]};
      px_o  <= px_i;
      pk_o  <= pk_i;
      a_o   <= a_i;
    end
  end

endmodule

[hdl/skc_mix.sv]
// Weighted mix of the two logs and rounding to integer and fraction parts of the
// exponent. Two register stages (multiply, then sum and round). Uses skc_pkg.
module skc_mix #(
  parameter int W = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  skc_pkg::skc_ctrl_t          ctrl_i,
  input  logic [W-1:0]                x_i,
  input  logic [skc_pkg::FRAC_Q-1:0]  frx_i,
  input  logic [skc_pkg::FRAC_Q-1:0]  frk_i,
  input  logic [$clog2(W)-1:0]        px_i,
  input  logic [$clog2(W)-1:0]        pk_i,
  input  logic [skc_pkg::RATIO_W-1:0] a_i,
  output skc_pkg::skc_ctrl_t          ctrl_o,
  output logic [W-1:0]                x_o,
  output logic [skc_pkg::IP_W-1:0]    ip_o,
  output logic [skc_pkg::FRAC_Q-1:0]  f_o
);
  localparam int EW = skc_pkg::EXPO_W;
  localparam int ZW = skc_pkg::PROD_W + 1;

  logic [EW-1:0]                       ex, ek;
  logic signed [skc_pkg::LOG_W-1:0]    lx, lk;
  logic [skc_pkg::RATIO_W-1:0]         b;
  logic signed [skc_pkg::PROD_W-1:0]   pa_nxt, pb_nxt, pa_r, pb_r;
  skc_pkg::skc_ctrl_t                  m_ctrl_r;
  logic [W-1:0]                        m_x_r;
  logic signed [ZW-1:0]                z;
  logic [ZW-1:0]                       nsum;

  always_comb begin
    ex     = EW'(px_i) - EW'(W - 1);
    ek     = EW'(pk_i) - EW'(W - 1);
    lx     = $signed({ex, frx_i});
    lk     = $signed({ek, frk_i});
    b      = skc_pkg::RATIO_ONE - a_i;
    pa_nxt = $signed({1'b0, a_i}) * lx;
    pb_nxt = $signed({1'b0, b}) * lk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_ctrl_r.valid <= 1'b0;
    end else if (en) begin
      m_ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      m_x_r <= x_i;
    end
  end

  always_comb begin
    z    = ZW'(pa_r) + ZW'(pb_r);
    nsum = ZW'(-z) + ZW'(32768);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o <= m_ctrl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o  <= m_x_r;
      ip_o <= nsum[skc_pkg::FRAC_Q+skc_pkg::N_W-1:2*skc_pkg::FRAC_Q];
      f_o  <= nsum[2*skc_pkg::FRAC_Q-1:skc_pkg::FRAC_Q];
    end
  end

endmodule

[hdl/skc_sqrt_step.sv]
// One digit of the integer square root used by exp2. The first digit of each root
// also halves the running value when its fraction bit is set. Uses skc_pkg.
module skc_sqrt_step #(
  parameter int W     = 24,
  parameter int ITER  = 0,
  parameter int F_BIT = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  skc_pkg::skc_ctrl_t         ctrl_i,
  input  logic [W-1:0]               x_i,
  input  logic [skc_pkg::IP_W-1:0]   ip_i,
  input  logic [skc_pkg::FRAC_Q-1:0] f_i,
  input  logic [skc_pkg::VAL_W-1:0]  v_i,
  input  logic [skc_pkg::VAL_W-1:0]  res_i,
  output skc_pkg::skc_ctrl_t         ctrl_o,
  output logic [W-1:0]               x_o,
  output logic [skc_pkg::IP_W-1:0]   ip_o,
  output logic [skc_pkg::FRAC_Q-1:0] f_o,
  output logic [skc_pkg::VAL_W-1:0]  v_o,
  output logic [skc_pkg::VAL_W-1:0]  res_o
);
  localparam int VW = skc_pkg::VAL_W;
  localparam logic [VW-1:0] BITV = {{(VW-1){1'b0}}, 1'b1} << (60 - 2 * ITER);

  logic [skc_pkg::ROOT_W-1:0] r_h;
  logic [VW-1:0]              v_in, res_in, trial, v_nxt, res_nxt;

  always_comb begin
    r_h = f_i[F_BIT] ? (res_i[skc_pkg::ROOT_W-1:0] >> 1) : res_i[skc_pkg::ROOT_W-1:0];
    if (ITER == 0) begin
      v_in   = VW'(r_h) << 30;
      res_in = '0;
    end else begin
      v_in   = v_i;
      res_in = res_i;
    end
    trial = res_in + BITV;
    if (v_in >= trial) begin
      v_nxt   = v_in - trial;
      res_nxt = (res_in >> 1) + BITV;
    end else begin
      v_nxt   = v_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o   <= x_i;
      ip_o  <= ip_i;
      f_o   <= f_i;
      v_o   <= v_nxt;
      res_o <= res_nxt;
    end
  end

endmodule

[hdl/skc_back.sv]
// Back end: scale the exp2 result by the integer exponent with rounding, pick the
// pass-through path, restore the sign and saturate into the output register. Uses skc_pkg.
module skc_back #(
  parameter int W = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  skc_pkg::skc_ctrl_t         ctrl_i,
  input  logic [W-1:0]               x_i,
  input  logic [skc_pkg::IP_W-1:0]   ip_i,
  input  logic [skc_pkg::ROOT_W-1:0] r_i,
  output logic                       valid_o,
  output logic [W-1:0]               sample_o
);
  localparam logic [63:0] FS64 = 64'd1 << (W - 1);

  logic [6:0]   s;
  logic [63:0]  t, tsum, yb, y, yc;
  logic [W-1:0] out_nxt;

  always_comb begin
    t    = {31'd0, r_i, 2'b00};
    s    = 7'(33 - W) + 7'(ip_i);
    tsum = t + (64'd1 << (s - 7'd1));
    if (s >= 7'd63) begin
      yb = '0;
    end else if (s == 7'd0) begin
      yb = t;
    end else begin
      yb = tsum >> s;
    end
    y  = ctrl_i.bypass ? 64'(x_i) : yb;
    yc = (y > FS64) ? FS64 : y;
    if (ctrl_i.neg) begin
      out_nxt = W'(-yc);
    end else if (yc > FS64 - 64'd1) begin
      out_nxt = W'(FS64 - 64'd1);
    end else begin
      out_nxt = yc[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_o <= out_nxt;
    end
  end

endmodule

[hdl/soft_knee_compressor_curve_unit.sv]
// Soft-knee compressor static curve: one signed sample per word, log2/exp2 pipeline.
// Stages from input to output: front end, log steps, mix, root steps, then the output register.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Reset (synchronous, rst_n low) empties the pipeline and loads full-scale levels
// and unity inverse ratios. Uses skc_pkg, skc_if and the skc_* stage modules.
module soft_knee_compressor_curve_unit #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  skc_in_if.sink     in_s,
  skc_out_if.source  out_s,
  skc_cfg_if.sink    cfg_s
);
  localparam int W   = SAMPLE_WIDTH;
  localparam int PW  = $clog2(W);
  localparam int NL  = skc_pkg::LOG_STEPS;
  localparam int NS  = skc_pkg::SQ_STAGES;
  localparam int NI  = skc_pkg::SQRT_ITERS;

  logic [skc_pkg::LEVEL_W-1:0] k_low_r, k_high_r, thr_r;
  logic [skc_pkg::RATIO_W-1:0] knee_a_r, full_a_r;
  logic                        en;

  skc_pkg::skc_ctrl_t          lg_ctrl [0:NL];
  logic [W-1:0]                lg_x    [0:NL];
  logic [W-1:0]                lg_mx   [0:NL];
  logic [W-1:0]                lg_mk   [0:NL];
  logic [skc_pkg::FRAC_Q-1:0]  lg_frx  [0:NL];
  logic [skc_pkg::FRAC_Q-1:0]  lg_frk  [0:NL];
  logic [PW-1:0]               lg_px   [0:NL];
  logic [PW-1:0]               lg_pk   [0:NL];
  logic [skc_pkg::RATIO_W-1:0] lg_a    [0:NL];

  skc_pkg::skc_ctrl_t          sq_ctrl [0:NS];
  logic [W-1:0]                sq_x    [0:NS];
  logic [skc_pkg::IP_W-1:0]    sq_ip   [0:NS];
  logic [skc_pkg::FRAC_Q-1:0]  sq_f    [0:NS];
  logic [skc_pkg::VAL_W-1:0]   sq_v    [0:NS];
  logic [skc_pkg::VAL_W-1:0]   sq_res  [0:NS];

  logic                        out_valid;
  logic [W-1:0]                out_sample;

  assign en          = !out_valid || out_s.ready;
  assign in_s.ready  = en;
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_low_r  <= skc_pkg::LEVEL_RESET;
      k_high_r <= skc_pkg::LEVEL_RESET;
      thr_r    <= skc_pkg::LEVEL_RESET;
      knee_a_r <= skc_pkg::RATIO_ONE;
      full_a_r <= skc_pkg::RATIO_ONE;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        skc_pkg::REG_KNEE_LOW:  k_low_r  <= cfg_s.data;
        skc_pkg::REG_KNEE_HIGH: k_high_r <= cfg_s.data;
        skc_pkg::REG_THRESHOLD: thr_r    <= cfg_s.data;
        skc_pkg::REG_KNEE_INV:  knee_a_r <= cfg_s.data[skc_pkg::RATIO_W-1:0];
        skc_pkg::REG_INV_RATIO: full_a_r <= cfg_s.data[skc_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  skc_front #(.W(W)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_s.valid),
    .sample  (in_s.sample_in),
    .k_low   (k_low_r),
    .k_high  (k_high_r),
    .thr     (thr_r),
    .knee_a  (knee_a_r),
    .full_a  (full_a_r),
    .ctrl_o  (lg_ctrl[0]),
    .x_o     (lg_x[0]),
    .mx_o    (lg_mx[0]),
    .mk_o    (lg_mk[0]),
    .px_o    (lg_px[0]),
    .pk_o    (lg_pk[0]),
    .a_o     (lg_a[0])
  );

  assign lg_frx[0] = '0;
  assign lg_frk[0] = '0;

  for (genvar g = 0; g < NL; g++) begin : g_log
    skc_log_step #(.W(W)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctrl_i(lg_ctrl[g]),
      .x_i   (lg_x[g]),
      .mx_i  (lg_mx[g]),
      .mk_i  (lg_mk[g]),
      .frx_i (lg_frx[g]),
      .frk_i (lg_frk[g]),
      .px_i  (lg_px[g]),
      .pk_i  (lg_pk[g]),
      .a_i   (lg_a[g]),
      .ctrl_o(lg_ctrl[g+1]),
      .x_o   (lg_x[g+1]),
      .mx_o  (lg_mx[g+1]),
      .mk_o  (lg_mk[g+1]),
      .frx_o (lg_frx[g+1]),
      .frk_o (lg_frk[g+1]),
      .px_o  (lg_px[g+1]),
      .pk_o  (lg_pk[g+1]),
      .a_o   (lg_a[g+1])
    );
  end

  skc_mix #(.W(W)) u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctrl_i(lg_ctrl[NL]),
    .x_i   (lg_x[NL]),
    .frx_i (lg_frx[NL]),
    .frk_i (lg_frk[NL]),
    .px_i  (lg_px[NL]),
    .pk_i  (lg_pk[NL]),
    .a_i   (lg_a[NL]),
    .ctrl_o(sq_ctrl[0]),
    .x_o   (sq_x[0]),
    .ip_o  (sq_ip[0]),
    .f_o   (sq_f[0])
  );

  assign sq_v[0]   = '0;
  assign sq_res[0] = skc_pkg::VAL_W'(skc_pkg::ROOT_ONE);

  for (genvar g = 0; g < NS; g++) begin : g_root
    skc_sqrt_step #(.W(W), .ITER(g % NI), .F_BIT(g / NI)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctrl_i(sq_ctrl[g]),
      .x_i   (sq_x[g]),
      .ip_i  (sq_ip[g]),
      .f_i   (sq_f[g]),
      .v_i   (sq_v[g]),
      .res_i (sq_res[g]),
      .ctrl_o(sq_ctrl[g+1]),
      .x_o   (sq_x[g+1]),
      .ip_o  (sq_ip[g+1]),
      .f_o   (sq_f[g+1]),
      .v_o   (sq_v[g+1]),
      .res_o (sq_res[g+1])
    );
  end

  skc_back #(.W(W)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctrl_i  (sq_ctrl[NS]),
    .x_i     (sq_x[NS]),
    .ip_i    (sq_ip[NS]),
    .r_i     (sq_res[NS][skc_pkg::ROOT_W-1:0]),
    .valid_o (out_valid),
    .sample_o(out_sample)
  );

  assign out_s.valid      = out_valid;
  assign out_s.sample_out = out_sample;

  a_stall_holds_root: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sq_ctrl[NS]) && $stable(lg_ctrl[NL]))
    else $error("Pipeline moved during a stall.");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !sq_ctrl[NS].valid && !lg_ctrl[0].valid)
    else $error("Pipeline not empty after reset.");

  a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_s.ready)
    else $error("Input refused while the output register is empty.");

endmodule
